// ===== rtl/core/convolution_3x3_rgb_clamp_defines.svh =====
// Assertion macros shared by the convolution block.
`ifndef CONVOLUTION_3X3_RGB_CLAMP_DEFINES_SVH
`define CONVOLUTION_3X3_RGB_CLAMP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CV3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("convolution block check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CV3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("convolution block check failed");

`endif

// ===== rtl/core/cv3_pkg.sv =====
package cv3_pkg;

  localparam int MAX_LINE   = 1024;
  localparam int ADDR_W     = $clog2(MAX_LINE);
  localparam int DIM_W      = 11;
  localparam int COEF_BITS  = 8;
  localparam int COEF_REG_W = 3 * COEF_BITS;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int TAPS       = 9;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int ACC_W      = 20;
  localparam int DIV_STEPS  = ACC_W - 1;
  localparam int CNT_W      = 5;
  localparam int CFG_ADDR_W = 5;
  localparam int DIV_W      = 8;

  typedef enum logic [2:0] {
    REG_COEF_TOP    = 3'd0,
    REG_COEF_MIDDLE = 3'd1,
    REG_COEF_BOTTOM = 3'd2,
    REG_DIVISOR     = 3'd3,
    REG_WIDTH       = 3'd4,
    REG_HEIGHT      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } lane_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              frame_done;
  } pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_W'(3)) begin
      return DIM_W'(3);
    end else if (v > DIM_W'(MAX_LINE)) begin
      return DIM_W'(MAX_LINE);
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/cv3_lane.sv =====
module cv3_lane
  import cv3_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                ack,
  input  logic [TAPS-1:0][PIX_W-1:0]          samples,
  input  logic [TAPS-1:0][COEF_BITS-1:0]      coefs,
  input  logic [DIV_W-1:0]                    divisor,
  output lane_res_t                           res
);

  typedef enum logic [1:0] {L_IDLE, L_MAC, L_DIV, L_DONE} lane_state_t;

  lane_state_t               state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [DIV_STEPS-1:0]      quo_r;
  logic [DIV_STEPS-1:0]      quo_nxt;
  logic [DIV_W-1:0]          rem_r;
  logic [DIV_W-1:0]          rem_nxt;
  logic [DIV_W:0]            trial;
  logic                      ge;
  logic [PIX_W-1:0]          value_r;
  logic [TAP_W-1:0]          tap;
  logic signed [PIX_W+COEF_BITS:0] prod;

  assign tap     = cnt_r[TAP_W-1:0];
  assign prod    = $signed({1'b0, samples[tap]}) * $signed(coefs[tap]);
  assign acc_nxt = acc_r + ACC_W'(prod);

  assign trial   = {rem_r, quo_r[DIV_STEPS-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
  assign quo_nxt = {quo_r[DIV_STEPS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= L_MAC;
          end
        end
        L_MAC: begin
          acc_r <= acc_nxt;
          if (cnt_r == CNT_W'(TAPS - 1)) begin
            cnt_r <= '0;
            if (acc_nxt < 0) begin
              value_r <= '0;
              state_r <= L_DONE;
            end else begin
              quo_r   <= acc_nxt[DIV_STEPS-1:0];
              rem_r   <= '0;
              state_r <= L_DIV;
            end
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        L_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            value_r <= (|quo_nxt[DIV_STEPS-1:PIX_W]) ? {PIX_W{1'b1}} : quo_nxt[PIX_W-1:0];
            state_r <= L_DONE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        L_DONE: begin
          if (ack) begin
            state_r <= L_IDLE;
          end
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  assign res.done  = (state_r == L_DONE);
  assign res.value = value_r;

endmodule

// ===== rtl/core/cv3_merge.sv =====
module cv3_merge
  import cv3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_res_t         res_red,
  input  lane_res_t         res_green,
  input  lane_res_t         res_blue,
  input  pos_t              pos,
  input  logic              out_stall,
  output logic              take,
  output logic              out_valid,
  output logic [PIX_W-1:0]  out_red,
  output logic [PIX_W-1:0]  out_green,
  output logic [PIX_W-1:0]  out_blue,
  output logic [ADDR_W-1:0] out_row,
  output logic [ADDR_W-1:0] out_col,
  output logic              out_frame_done
);

  logic             valid_r;
  logic [PIX_W-1:0] red_r;
  logic [PIX_W-1:0] green_r;
  logic [PIX_W-1:0] blue_r;
  pos_t             pos_r;

  assign take = res_red.done && res_green.done && res_blue.done && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
      red_r   <= res_red.value;
      green_r <= res_green.value;
      blue_r  <= res_blue.value;
      pos_r   <= pos;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid      = valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_row        = pos_r.row;
  assign out_col        = pos_r.col;
  assign out_frame_done = pos_r.frame_done;

endmodule

// ===== rtl/core/convolution_3x3_rgb_clamp.sv =====
// Input is stalled from an accepted pixel until it is done: a border pixel only shifts the
// window, an interior pixel waits for the nine-tap multiply-accumulate and the 19-step
// restoring divider in each lane (the divider is skipped when the sum is negative).
// The output register lets the next pixel be accepted while a result waits to be taken.
// Reset (synchronous, active low) restores the register defaults, clears the window and
// the position counters; the line store is not cleared and needs no clearing pass.
`include "convolution_3x3_rgb_clamp_defines.svh"

module convolution_3x3_rgb_clamp
  import cv3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_red,
  input  logic [PIX_W-1:0]      in_pixel_green,
  input  logic [PIX_W-1:0]      in_pixel_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  output logic [ADDR_W-1:0]     out_row,
  output logic [ADDR_W-1:0]     out_col,
  output logic                  out_frame_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_START, ST_BUSY} state_t;

  state_t                  state_r;
  logic [COEF_REG_W-1:0]   coef_top_r;
  logic [COEF_REG_W-1:0]   coef_mid_r;
  logic [COEF_REG_W-1:0]   coef_bot_r;
  logic [DIV_W-1:0]        divisor_r;
  logic [DIM_W-1:0]        width_r;
  logic [DIM_W-1:0]        height_r;
  logic [DIM_W-1:0]        w;
  logic [DIM_W-1:0]        h;
  logic [DIV_W-1:0]        div_eff;
  reg_idx_t                reg_idx;
  logic                    cfg_wr;

  logic [ADDR_W-1:0]       col_r;
  logic [ADDR_W-1:0]       row_r;
  logic [RGB_W-1:0]        pix_r;
  logic [2*RGB_W-1:0]      line_mem [MAX_LINE];
  logic [2*RGB_W-1:0]      rd_q;
  logic [2:0][2:0][RGB_W-1:0] win_r;
  pos_t                    pos_r;

  logic                    accept;
  logic                    emit;
  logic                    take;
  logic                    lane_start;
  lane_res_t               res_red;
  lane_res_t               res_green;
  lane_res_t               res_blue;
  logic [TAPS-1:0][COEF_BITS-1:0] coefs;
  logic [2:0][TAPS-1:0][PIX_W-1:0] samples;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign w       = clamp_dim(width_r);
  assign h       = clamp_dim(height_r);
  assign div_eff = (divisor_r == '0) ? DIV_W'(1) : divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= COEF_REG_W'(1) << COEF_BITS;
      coef_bot_r <= '0;
      divisor_r  <= DIV_W'(1);
      width_r    <= DIM_W'(MAX_LINE);
      height_r   <= DIM_W'(MAX_LINE);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_TOP:    coef_top_r <= pwdata[COEF_REG_W-1:0];
        REG_COEF_MIDDLE: coef_mid_r <= pwdata[COEF_REG_W-1:0];
        REG_COEF_BOTTOM: coef_bot_r <= pwdata[COEF_REG_W-1:0];
        REG_DIVISOR:     divisor_r  <= pwdata[DIV_W-1:0];
        REG_WIDTH:       width_r    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:      height_r   <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_TOP:    prdata = 32'(coef_top_r);
      REG_COEF_MIDDLE: prdata = 32'(coef_mid_r);
      REG_COEF_BOTTOM: prdata = 32'(coef_bot_r);
      REG_DIVISOR:     prdata = 32'(divisor_r);
      REG_WIDTH:       prdata = 32'(width_r);
      REG_HEIGHT:      prdata = 32'(height_r);
      default:         prdata = '0;
    endcase
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign lane_start = (state_r == ST_START);
  assign emit       = (row_r >= ADDR_W'(2)) && (col_r >= ADDR_W'(2)) &&
                      (DIM_W'(row_r) < h) && (DIM_W'(col_r) < w);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col_r];
    end
    if (state_r == ST_SHIFT) begin
      line_mem[col_r] <= {rd_q[RGB_W-1:0], pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            pix_r   <= {in_pixel_blue, in_pixel_green, in_pixel_red};
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k][0] <= win_r[k][1];
            win_r[k][1] <= win_r[k][2];
          end
          win_r[0][2] <= rd_q[2*RGB_W-1:RGB_W];
          win_r[1][2] <= rd_q[RGB_W-1:0];
          win_r[2][2] <= pix_r;
          pos_r.row        <= row_r - ADDR_W'(1);
          pos_r.col        <= col_r - ADDR_W'(1);
          pos_r.frame_done <= (DIM_W'(row_r) == h - DIM_W'(1)) &&
                              (DIM_W'(col_r) == w - DIM_W'(1));
          if (DIM_W'(col_r) + DIM_W'(1) >= w) begin
            col_r <= '0;
            row_r <= (DIM_W'(row_r) + DIM_W'(1) >= h) ? '0 : row_r + ADDR_W'(1);
          end else begin
            col_r <= col_r + ADDR_W'(1);
          end
          state_r <= emit ? ST_START : ST_IDLE;
        end
        ST_START: begin
          state_r <= ST_BUSY;
        end
        ST_BUSY: begin
          if (take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int ch = 0; ch < 3; ch++) begin
          samples[ch][r*3+c] = win_r[r][c][ch*PIX_W +: PIX_W];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      coefs[c]     = coef_top_r[c*COEF_BITS +: COEF_BITS];
      coefs[3 + c] = coef_mid_r[c*COEF_BITS +: COEF_BITS];
      coefs[6 + c] = coef_bot_r[c*COEF_BITS +: COEF_BITS];
    end
  end

  cv3_lane u_lane_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lane_start),
    .ack     (take),
    .samples (samples[0]),
    .coefs   (coefs),
    .divisor (div_eff),
    .res     (res_red)
  );

  cv3_lane u_lane_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lane_start),
    .ack     (take),
    .samples (samples[1]),
    .coefs   (coefs),
    .divisor (div_eff),
    .res     (res_green)
  );

  cv3_lane u_lane_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lane_start),
    .ack     (take),
    .samples (samples[2]),
    .coefs   (coefs),
    .divisor (div_eff),
    .res     (res_blue)
  );

  cv3_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_red        (res_red),
    .res_green      (res_green),
    .res_blue       (res_blue),
    .pos            (pos_r),
    .out_stall      (out_stall),
    .take           (take),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

  `CV3_ASSERT_NEXT(a_accept_to_shift, clk, rst_n, accept, state_r == ST_SHIFT)
  `CV3_ASSERT_SAME(a_take_only_busy, clk, rst_n, take, state_r == ST_BUSY)
  `CV3_ASSERT_NEXT(a_border_no_work, clk, rst_n, (state_r == ST_SHIFT) && !emit, state_r == ST_IDLE)

endmodule

// ===== verif/convolution_3x3_rgb_clamp_test.sv =====
`timescale 1ns / 100ps

module convolution_3x3_rgb_clamp_test;
  import cv3_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              done;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] in_pixel_red = '0;
  logic [PIX_W-1:0] in_pixel_green = '0;
  logic [PIX_W-1:0] in_pixel_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic [ADDR_W-1:0] out_row;
  logic [ADDR_W-1:0] out_col;
  logic out_frame_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  convolution_3x3_rgb_clamp u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the filter settings and of the pixel history.
  logic [COEF_REG_W-1:0] coef_rows [3];
  logic [7:0] div_setting;
  logic [10:0] width_setting;
  logic [10:0] height_setting;
  logic [47:0] line_hist [MAX_LINE];
  logic [23:0] win [3][3];
  int col_pos;
  int row_pos;

  pixel_t pixel_q [$];
  filtered_t filtered_q [$];
  int pixels_queued = 0;
  int mismatches = 0;
  longint cycles = 0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;

  function automatic int eff_dim(logic [10:0] v);
    if (v < 3) return 3;
    if (v > MAX_LINE) return MAX_LINE;
    return int'(v);
  endfunction

  function automatic logic [7:0] filter_lane(int shift);
    int sum;
    int d;
    sum = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum += int'(win[r][c][shift +: 8]) * int'($signed(coef_rows[r][8*c +: 8]));
      end
    end
    d = (div_setting == 0) ? 1 : int'(div_setting);
    sum = sum / d;
    if (sum < 0) return 8'd0;
    if (sum > 255) return 8'd255;
    return sum[7:0];
  endfunction

  task automatic filter_pixel(logic [23:0] pix);
    int w;
    int h;
    logic [47:0] entry;
    filtered_t res;
    w = eff_dim(width_setting);
    h = eff_dim(height_setting);
    entry = line_hist[col_pos];
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = entry[47:24];
    win[1][2] = entry[23:0];
    win[2][2] = pix;
    line_hist[col_pos] = {entry[23:0], pix};
    if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
      res.red = filter_lane(0);
      res.green = filter_lane(8);
      res.blue = filter_lane(16);
      res.row = ADDR_W'(row_pos - 1);
      res.col = ADDR_W'(col_pos - 1);
      res.done = (row_pos == h - 1) && (col_pos == w - 1);
      filtered_q.push_back(res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      filter_pixel({in_pixel_blue, in_pixel_green, in_pixel_red});
    end
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected word: row %0d col %0d", out_row, out_col);
        end
      end else begin
        filtered_t e;
        e = filtered_q.pop_front();
        if (out_red !== e.red || out_green !== e.green || out_blue !== e.blue ||
            out_row !== e.row || out_col !== e.col || out_frame_done !== e.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected rgb %0d %0d %0d pos %0d,%0d done %0d",
                     e.red, e.green, e.blue, e.row, e.col, e.done);
            $display("          actual   rgb %0d %0d %0d pos %0d,%0d done %0d",
                     out_red, out_green, out_blue, out_row, out_col, out_frame_done);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel_t p;
        p = pixel_q.pop_front();
        in_pixel_red <= p.red;
        in_pixel_green <= p.green;
        in_pixel_blue <= p.blue;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 20);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(4, 10);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COEF_TOP: coef_rows[0] = value[COEF_REG_W-1:0];
      REG_COEF_MIDDLE: coef_rows[1] = value[COEF_REG_W-1:0];
      REG_COEF_BOTTOM: coef_rows[2] = value[COEF_REG_W-1:0];
      REG_DIVISOR: div_setting = value[7:0];
      REG_WIDTH: width_setting = value[10:0];
      REG_HEIGHT: height_setting = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(logic [31:0] top, logic [31:0] mid, logic [31:0] bot,
                            logic [31:0] dv, logic [31:0] w, logic [31:0] h);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MIDDLE, mid);
    write_reg(REG_COEF_BOTTOM, bot);
    write_reg(REG_DIVISOR, dv);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // mode 0: random samples, 1: all 255, 2: all 0.
  task automatic queue_pixels(int count, int mode);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      if (mode == 1) begin
        p = '{8'hff, 8'hff, 8'hff};
      end else if (mode == 2) begin
        p = '{8'h00, 8'h00, 8'h00};
      end else if ($urandom_range(0, 9) == 0) begin
        p.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end else begin
        p.red = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.blue = 8'($urandom_range(0, 255));
      end
      pixel_q.push_back(p);
    end
    pixels_queued += count;
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || filtered_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic run_frame(int mode);
    int n;
    n = eff_dim(width_setting) * eff_dim(height_setting);
    queue_pixels(n, mode);
    drain();
  endtask

  initial begin
    logic [10:0] w;
    logic [10:0] h;
    coef_rows[0] = 24'd0;
    coef_rows[1] = 24'd256;
    coef_rows[2] = 24'd0;
    div_setting = 8'd1;
    width_setting = 11'd1024;
    height_setting = 11'd1024;
    for (int i = 0; i < MAX_LINE; i++) begin
      line_hist[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win[r][c] = '0;
      end
    end
    col_pos = 0;
    row_pos = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Default coefficients pass the center pixel through.
    write_reg(REG_WIDTH, 32'd5);
    write_reg(REG_HEIGHT, 32'd4);
    run_frame(0);

    set_filter(32'h007f7f7f, 32'h007f7f7f, 32'h007f7f7f, 32'd1, 32'd3, 32'd3);
    run_frame(1);
    set_filter(32'h00808080, 32'h00808080, 32'h00808080, 32'd1, 32'd4, 32'd3);
    run_frame(1);
    set_filter(32'hff7f807f, 32'h00808080, 32'h7f7f7f00, 32'd255, 32'd2, 32'd0);
    run_frame(1);

    // An oversized height acts as the longest frame, which is then closed early by a smaller height.
    set_filter(32'h00010101, 32'h00010101, 32'h00010101, 32'hffffff00, 32'd1, 32'd2047);
    queue_pixels(18, 2);
    drain();
    write_reg(REG_HEIGHT, 32'd7);
    queue_pixels(3, 2);
    drain();

    set_filter(32'h000000ff, 32'h00ff08ff, 32'h00ff0000, 32'd2, 32'd12, 32'd3);
    run_frame(0);

    // The sender holds off mid-frame until all pending words are out.
    set_filter($urandom, $urandom, $urandom, $urandom_range(1, 9), 32'd6, 32'd6);
    queue_pixels(17, 0);
    drain();
    queue_pixels(19, 0);
    drain();

    while (pixels_queued < 900) begin
      w = 11'($urandom_range(3, 12));
      h = 11'($urandom_range(3, 8));
      if ($urandom_range(0, 9) == 0) w = 11'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) h = 11'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        set_filter($urandom, $urandom, $urandom, $urandom, {21'd0, w}, {21'd0, h});
      end else begin
        write_reg(REG_DIVISOR, $urandom_range(1, 255));
        write_reg(REG_COEF_MIDDLE, $urandom);
        write_reg(REG_WIDTH, {21'd0, w});
        write_reg(REG_HEIGHT, {21'd0, h});
      end
      run_frame(0);
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== convolution_3x3_rgb_clamp.f =====
+incdir+rtl/core
rtl/core/cv3_pkg.sv
rtl/core/cv3_lane.sv
rtl/core/cv3_merge.sv
rtl/core/convolution_3x3_rgb_clamp.sv
verif/convolution_3x3_rgb_clamp_test.sv
